>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files that check themselves.
// Each macro samples on the rising clock edge and is quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define QPHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// The expression must never be true at a sampled edge.
`define QPHT_ASSERT_NEVER(label, expr, msg) \
   `QPHT_ASSERT(label, !(expr), msg)

`endif

>>> rtl/qpht_pkg.sv
`default_nettype none

package qpht_pkg;

   // Table geometry. The slot count is a power of two, so the home slot is
   // the low key bits and every probe position wraps for free.
   localparam int SLOT_W   = 6;
   localparam int CAPACITY = 1 << SLOT_W;
   localparam int CNT_W    = SLOT_W + 1;

   // Fixed field widths of the request and response channels.
   localparam int KEY_W     = 31;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int SLOT_OUT_W = 6;

   // Request kinds. The fourth code is unused and answers "not found".
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

   // Control sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_HOLD
   } state_type;

   typedef logic [SLOT_W-1:0] slot_type;

   // Map a table index onto the six-bit slot field.
   function automatic logic [SLOT_OUT_W-1:0] slot_field(input slot_type p);
      logic [31:0] wide;
      wide = 32'(p);
      return wide[SLOT_OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/qpht_ifs.sv
`default_nettype none

// Request channel: kind and key.
interface qpht_req_if
   import qpht_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [KEY_W-1:0]  key;

   modport source (output valid, output kind, output key, input ready);
   modport sink   (input valid, input kind, input key, output ready);
endinterface

// Response channel: status and slot.
interface qpht_rsp_if
   import qpht_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_OUT_W-1:0] slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

>>> rtl/quadratic_probe_hash_table_core.sv
//  channel    direction  payload              handshake
//  req_chan   in         kind[1:0] key[30:0]  valid/ready
//  rsp_chan   out        status[1:0] slot[5:0] valid/ready
//
//  A request visits k slots, 1 <= k <= 64; each visit is a key RAM read
//  in the read state, then the compare and update in the check state.
//  Reset is synchronous and clears the used and deleted flags; the key
//  RAM is not cleared. A new request is taken while the previous
//  response waits in the output register; a stalled response holds the
//  sequencer in its hold state once the next result is ready.
`default_nettype none
`include "assert_macros.svh"

module quadratic_probe_hash_table_core
   import qpht_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   qpht_req_if.sink    req_chan,
   qpht_rsp_if.source  rsp_chan
);

   // sequencer
   state_type state_ff, state_in;

   // request being worked on
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;

   // probe walker: position, odd step to next square, probes done
   slot_type         pos_ff, pos_in;
   slot_type         step_ff, step_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // slot flags, cleared by reset
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [CAPACITY-1:0] del_ff, del_in;
   logic                used_rd_ff, used_rd_in;
   logic                del_rd_ff, del_rd_in;

   // key RAM port
   logic [KEY_W-1:0] rd_key;
   logic             key_rd_en;
   logic             ins_we;
   logic             rem_we;

   // result of the current probe
   logic                res_done;
   logic [STATUS_W-1:0] res_status;
   logic                last_probe;

   // pending result while the output register is full
   logic [STATUS_W-1:0]   pend_status_ff, pend_status_in;
   logic [SLOT_OUT_W-1:0] pend_slot_ff, pend_slot_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  out_free;
   logic                  req_take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;

   qpht_key_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ins_we),
      .wr_addr (pos_ff),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_key)
   );

   // probe decision, valid in the check state
   assign last_probe = (cnt_ff == CNT_W'(CAPACITY - 1));

   always_comb begin
      res_done   = 1'b0;
      res_status = STAT_NOT_FOUND;
      ins_we     = 1'b0;
      rem_we     = 1'b0;
      if (state_ff == ST_CHECK) begin
         case (kind_ff) inside
            KIND_INSERT: begin
               if (!used_rd_ff || del_rd_ff) begin
                  res_done   = 1'b1;
                  res_status = STAT_OK;
                  ins_we     = 1'b1;
               end else if (last_probe) begin
                  res_done   = 1'b1;
                  res_status = STAT_FULL;
               end
            end
            KIND_SEARCH, KIND_REMOVE: begin
               if (!used_rd_ff) begin
                  res_done = 1'b1;
               end else if (!del_rd_ff && (rd_key == key_ff)) begin
                  res_done   = 1'b1;
                  res_status = STAT_OK;
                  rem_we     = (kind_ff == KIND_REMOVE);
               end else if (last_probe) begin
                  res_done = 1'b1;
               end
            end
            default: begin
               res_done = 1'b1;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_READ;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (!res_done)     state_in = ST_READ;
            else if (out_free) state_in = ST_IDLE;
            else               state_in = ST_HOLD;
         end
         ST_HOLD:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      key_rd_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_READ:  key_rd_en = 1'b1;
         ST_CHECK: ;
         ST_HOLD:  ;
         default:  ;
      endcase
   end

   // request capture and probe walk
   always_comb begin
      kind_in    = kind_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      used_rd_in = used_rd_ff;
      del_rd_in  = del_rd_ff;
      if (req_take) begin
         kind_in = req_chan.kind;
         key_in  = req_chan.key;
         pos_in  = req_chan.key[SLOT_W-1:0];
         step_in = SLOT_W'(1);
         cnt_in  = '0;
      end
      if (state_ff == ST_READ) begin
         used_rd_in = used_ff[pos_ff];
         del_rd_in  = del_ff[pos_ff];
      end
      if (state_ff == ST_CHECK && !res_done) begin
         pos_in  = pos_ff + step_ff;
         step_in = step_ff + SLOT_W'(2);
         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   // flag updates
   always_comb begin
      used_in = used_ff;
      del_in  = del_ff;
      if (ins_we) begin
         used_in[pos_ff] = 1'b1;
         del_in[pos_ff]  = 1'b0;
      end
      if (rem_we) begin
         del_in[pos_ff] = 1'b1;
      end
   end

   // output register and pending result
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_done) begin
         pend_status_in = res_status;
         pend_slot_in   = (res_status == STAT_OK) ? slot_field(pos_ff) : '0;
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = pend_status_in;
            rsp_slot_in   = pend_slot_in;
         end
      end
      if (state_ff == ST_HOLD && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_slot_in   = pend_slot_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         del_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         del_ff       <= del_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      pos_ff         <= pos_in;
      step_ff        <= step_in;
      cnt_ff         <= cnt_in;
      used_rd_ff     <= used_rd_in;
      del_rd_ff      <= del_rd_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;

   // checks
   `QPHT_ASSERT(a_slot_zero_on_fail,
      (rsp_chan.valid && rsp_chan.status != STAT_OK) |-> (rsp_chan.slot == '0),
      "nonzero slot on a failed response")
   `QPHT_ASSERT(a_accept_starts_read, req_take |=> (state_ff == ST_READ),
      "accepted request did not start a probe")
   `QPHT_ASSERT_NEVER(a_probe_overrun,
      (state_ff == ST_CHECK) && (cnt_ff >= CNT_W'(CAPACITY)),
      "probe count passed the table size")
   `QPHT_ASSERT_NEVER(a_hold_with_free_out,
      (state_ff == ST_HOLD) && $past(state_ff == ST_CHECK) && $past(out_free),
      "result parked although the output register was free")

endmodule

`default_nettype wire

>>> rtl/qpht_key_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module qpht_key_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 31,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> tb/quadratic_probe_hash_table_core_tb.sv
`timescale 1ns / 100ps

module quadratic_probe_hash_table_core_tb;
   import qpht_pkg::*;

   // Unused request code; the block answers it with "not found"
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [KEY_W-1:0]  KEY_MAX     = 31'h7FFF_FFFF;

   localparam int RANDOM_PER_PHASE = 360;
   localparam int POOL_DEPTH       = 64;
   localparam int DRAIN_CYCLES     = 2 * CAPACITY + 8;
   localparam int LIMIT_CYCLES     = 2_000_000;
   localparam int REPORT_MAX       = 10;

   // One row of the directed sequence; typed rows carry their own answer
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [KEY_W-1:0]      key;
      logic                  typed;
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
   } probe_case_type;

   // Answer owed for one accepted request
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [KEY_W-1:0]      key;
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
   } lookup_answer_type;

   logic clock;
   logic reset = 1'b1;

   qpht_req_if req_chan ();
   qpht_rsp_if rsp_chan ();

   quadratic_probe_hash_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the table
   logic [KEY_W-1:0] shadow_keys    [CAPACITY];
   bit               shadow_used    [CAPACITY];
   bit               shadow_deleted [CAPACITY];
   logic [CNT_W-1:0] shadow_live;

   lookup_answer_type answers_due [$];
   logic [KEY_W-1:0]  key_pool [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int ok_responses = 0;
   int miss_responses = 0;
   int full_responses = 0;
   int cycle_count = 0;

   // Directed rows: empty-table lookups, extreme keys, unused code, filling one
   // probe chain until full, probe limit, removal, reuse of a deleted slot
   probe_case_type directed_rows [0:24] = '{
      '{KIND_SEARCH, 31'd0,    1'b1, STAT_NOT_FOUND, 6'd0},
      '{KIND_REMOVE, KEY_MAX,  1'b1, STAT_NOT_FOUND, 6'd0},
      '{KIND_UNUSED, 31'd5,    1'b1, STAT_NOT_FOUND, 6'd0},
      '{KIND_INSERT, 31'd0,    1'b1, STAT_OK,        6'd0},
      '{KIND_INSERT, KEY_MAX,  1'b1, STAT_OK,        6'd63},
      '{KIND_SEARCH, KEY_MAX,  1'b1, STAT_OK,        6'd63},
      '{KIND_INSERT, 31'd64,   1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd128,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd192,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd256,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd320,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd384,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd448,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd512,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd576,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd640,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd704,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd768,  1'b1, STAT_FULL,      6'd0},
      '{KIND_SEARCH, 31'd1280, 1'b1, STAT_NOT_FOUND, 6'd0},
      '{KIND_REMOVE, 31'd192,  1'b0, STAT_OK,        6'd0},
      '{KIND_SEARCH, 31'd320,  1'b0, STAT_OK,        6'd0},
      '{KIND_INSERT, 31'd320,  1'b0, STAT_OK,        6'd0},
      '{KIND_SEARCH, 31'd320,  1'b0, STAT_OK,        6'd0},
      '{KIND_UNUSED, KEY_MAX,  1'b1, STAT_NOT_FOUND, 6'd0},
      '{KIND_REMOVE, 31'd0,    1'b1, STAT_OK,        6'd0}
   };

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow table and return its answer
   function automatic lookup_answer_type probe_and_update(input logic [KIND_W-1:0] kind,
                                                           input logic [KEY_W-1:0] key);
      lookup_answer_type ans;
      slot_type          home;
      slot_type          pos;
      bit                done;
      ans.kind   = kind;
      ans.key    = key;
      ans.status = STAT_NOT_FOUND;
      ans.slot   = '0;
      home = key[SLOT_W-1:0];
      done = 1'b0;
      if (kind == KIND_INSERT) begin
         ans.status = STAT_FULL;
         for (int i = 0; i < CAPACITY; i++) begin
            pos = home + slot_type'(i * i);
            if (!done && (!shadow_used[pos] || shadow_deleted[pos])) begin
               shadow_keys[pos]    = key;
               shadow_used[pos]    = 1'b1;
               shadow_deleted[pos] = 1'b0;
               shadow_live         = shadow_live + 1'b1;
               ans.status = STAT_OK;
               ans.slot   = pos;
               done = 1'b1;
            end
         end
      end else if (kind == KIND_SEARCH || kind == KIND_REMOVE) begin
         for (int i = 0; i < CAPACITY; i++) begin
            pos = home + slot_type'(i * i);
            if (!done) begin
               if (!shadow_used[pos]) begin
                  done = 1'b1;
               end else if (!shadow_deleted[pos] && shadow_keys[pos] == key) begin
                  ans.status = STAT_OK;
                  ans.slot   = pos;
                  done = 1'b1;
                  if (kind == KIND_REMOVE) begin
                     shadow_deleted[pos] = 1'b1;
                     shadow_live = shadow_live - 1'b1;
                  end
               end
            end
         end
      end
      return ans;
   endfunction

   // Present one request, idling first at the current rate; returns at acceptance
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.kind  <= KIND_W'($urandom());
         req_chan.key   <= KEY_W'($urandom());
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind  <= kind;
      req_chan.key   <= key;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      requests_sent++;
   endtask

   // Keys mostly revisit earlier ones or crowd a few home slots
   function automatic logic [KEY_W-1:0] choose_key();
      logic [KEY_W-1:0] key;
      int               sel;
      sel = $urandom_range(99);
      key = KEY_W'($urandom());
      if (sel < 50 && key_pool.size() != 0) begin
         key = key_pool[$urandom_range(key_pool.size() - 1)];
      end else if (sel < 85) begin
         key[SLOT_W-1:0] = slot_type'($urandom_range(7));
      end
      return key;
   endfunction

   // Random requests; inserts favored until the table is fairly loaded
   task automatic run_random_requests(input int count);
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      int                pick;
      int                insert_pct;
      for (int n = 0; n < count; n++) begin
         insert_pct = (shadow_live < 40) ? 45 : 25;
         pick = $urandom_range(99);
         if (pick < insert_pct) kind = KIND_INSERT;
         else if (pick < 70) kind = KIND_SEARCH;
         else if (pick < 95) kind = KIND_REMOVE;
         else kind = KIND_UNUSED;
         key = choose_key();
         send_request(kind, key);
         answers_due.push_back(probe_and_update(kind, key));
         if (kind == KIND_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
         end
      end
   endtask

   // Response side: random stalls, compare each answer with the oldest one owed
   initial begin
      lookup_answer_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
               case (rsp_chan.status)
                  STAT_OK:        ok_responses++;
                  STAT_NOT_FOUND: miss_responses++;
                  default:        full_responses++;
               endcase
               if (answers_due.size() == 0) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("unexpected response: status %0d slot %0d",
                              rsp_chan.status, rsp_chan.slot);
               end else begin
                  want = answers_due.pop_front();
                  if (rsp_chan.status !== want.status || rsp_chan.slot !== want.slot) begin
                     mismatch_count++;
                     if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch kind %0d key %0d: expected status %0d ",
                                  "slot %0d, got status %0d slot %0d"},
                                 want.kind, want.key, want.status, want.slot,
                                 rsp_chan.status, rsp_chan.slot);
                  end
               end
            end
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               answers_due.size());
      $display("FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      lookup_answer_type predicted;
      probe_case_type    row;
      req_chan.valid <= 1'b0;
      req_chan.kind  <= KIND_INSERT;
      req_chan.key   <= '0;
      shadow_live = '0;
      for (int s = 0; s < CAPACITY; s++) begin
         shadow_keys[s]    = '0;
         shadow_used[s]    = 1'b0;
         shadow_deleted[s] = 1'b0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles 35%, receiver 70%
      send_idle_pct = 35;
      recv_idle_pct = 70;
      for (int r = 0; r < 25; r++) begin
         row = directed_rows[r];
         send_request(row.kind, row.key);
         predicted = probe_and_update(row.kind, row.key);
         if (row.typed) begin
            predicted.status = row.status;
            predicted.slot   = row.slot;
         end
         answers_due.push_back(predicted);
         if (row.kind == KIND_INSERT) key_pool.push_back(row.key);
      end
      run_random_requests(RANDOM_PER_PHASE);

      // Phase two: the other way round
      send_idle_pct = 70;
      recv_idle_pct = 35;
      run_random_requests(RANDOM_PER_PHASE);

      // Phase three: full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_requests(RANDOM_PER_PHASE);
      req_chan.valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over three stall profiles in %0d cycles", requests_sent,
               cycle_count);
      $display("answers: %0d ok, %0d not found, %0d table full; %0d mismatches",
               ok_responses, miss_responses, full_responses, mismatch_count);
      if (mismatch_count == 0 && answers_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
